// ===== design/tll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tll_pkg: shared types and constants for the tank level linearizer
// Holds the breakpoint ROM, the job word passed from search to compute, and
// the fixed thresholds used for bar level and label bucket decoding.
// ----------------------------------------------------------------------------
package tll_pkg;

    localparam int H_W      = 12;   // height field width
    localparam int STEP_W   = 12;   // step_volume width
    localparam int VOL_W    = 17;   // volume field width
    localparam int BAR_W    = 3;
    localparam int LBL_W    = 7;
    localparam int IDX_W    = 6;    // breakpoint index width
    localparam int ROM_DEPTH = 64;
    localparam int PT_W     = 11;   // breakpoint value width
    localparam int PROD_W   = PT_W + STEP_W;  // dh * step
    localparam int QUO_W    = STEP_W;         // frac < step
    localparam int BASE_W   = IDX_W + STEP_W; // idx * step
    localparam int SUM_W    = BASE_W + 1;
    localparam int SMALL_POINTS = 11;

    // configuration register indexes
    typedef enum logic {
        REG_TANK_MODE   = 1'b0,
        REG_STEP_VOLUME = 1'b1
    } t_cfg_reg;

    // floor(v / 250) as (v * LBL_RECIP) >> LBL_SHIFT, exact for v < 59074
    localparam int KQ_W       = 10;
    localparam int RECIP_W    = 16;
    localparam logic [RECIP_W-1:0] LBL_RECIP = 16'd33555;
    localparam int LBL_SHIFT  = 23;
    localparam logic [7:0] LBL_BUCKET = 8'd250;
    localparam logic [7:0] LBL_SPAN_MAX = 8'd240;

    localparam logic [LBL_W-1:0] LBL_FULL_SMALL = 7'd30;
    localparam logic [LBL_W-1:0] LBL_FULL_LARGE = 7'd112;
    localparam logic [VOL_W-1:0] FULL_LO_SMALL  = 17'd7500;
    localparam logic [VOL_W-1:0] FULL_LO_LARGE  = 17'd28000;
    localparam logic [VOL_W-1:0] FULL_MAX_SMALL = 17'd10000;
    localparam logic [VOL_W-1:0] FULL_MAX_LARGE = 17'd30000;

    // small tank: level 0 at or below 500, then strict upper bounds
    localparam logic [VOL_W-1:0] BAR_S0 = 17'd500;
    localparam logic [VOL_W-1:0] BAR_S1 = 17'd1200;
    localparam logic [VOL_W-1:0] BAR_S2 = 17'd2400;
    localparam logic [VOL_W-1:0] BAR_S3 = 17'd3600;
    localparam logic [VOL_W-1:0] BAR_S4 = 17'd4800;
    // large tank: inclusive upper bounds
    localparam logic [VOL_W-1:0] BAR_L0 = 17'd1000;
    localparam logic [VOL_W-1:0] BAR_L1 = 17'd10500;
    localparam logic [VOL_W-1:0] BAR_L2 = 17'd16000;
    localparam logic [VOL_W-1:0] BAR_L3 = 17'd21500;
    localparam logic [VOL_W-1:0] BAR_L4 = 17'd27000;

    localparam logic [PT_W-1:0] LEVEL_ROM [ROM_DEPTH] = '{
        11'd0,    11'd100,  11'd161,  11'd211,  11'd259,  11'd299,  11'd335,  11'd374,
        11'd410,  11'd448,  11'd483,  11'd520,  11'd558,  11'd592,  11'd627,  11'd661,
        11'd695,  11'd728,  11'd763,  11'd793,  11'd827,  11'd861,  11'd897,  11'd933,
        11'd972,  11'd1011, 11'd1060, 11'd1110, 11'd1160, 11'd1210, 11'd1300, 11'd1300,
        11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300,
        11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300,
        11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300,
        11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300, 11'd1300
    };

    // one located interval, or a miss
    typedef struct packed {
        logic [PT_W-1:0]  dh;     // height above the interval's lower point
        logic [PT_W-1:0]  span;   // interval width, nonzero on a hit
        logic [IDX_W-1:0] idx;    // interval number
        logic             hit;
    } t_job;

endpackage : tll_pkg
`default_nettype wire

// ===== design/tank_level_linearizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tank_level_linearizer: height to volume linearizer with display decode
// Converts an averaged level-sensor height into a volume in tenths of a litre
// by interpolation over a constant breakpoint table, plus bar level and label.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  -----------------------------
//  input     in         i_in_valid / o_in_ready   height_avg
//  output    out        o_out_valid / i_out_ready volume, in_table, bar, label
//  config    in         i_cfg_valid / o_cfg_ready index 0 tank_mode, 1 step
//
//  The search side takes one height word and walks the breakpoint ROM one
//  interval per cycle, up to POINTS - 1 intervals for the large tank; it
//  takes the next word only once the located interval is pushed. On a hit
//  the compute side multiplies, runs the restoring divider, adds the base
//  and decodes; beyond the table it only decodes; a two-entry queue sits
//  between the sides, and the output register lets a result wait while the
//  next word is searched. Synchronous active-low reset clears control state,
//  the held volume, and loads the register defaults; no memory clearing pass.
//
module tank_level_linearizer #(
    parameter int POINTS      = 31,
    parameter int HEIGHT_BITS = 12
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // height words
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [tll_pkg::H_W-1:0]       i_height_avg,
    // result words
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [tll_pkg::VOL_W-1:0]     o_volume_tenths,
    output logic                          o_in_table,
    output logic [tll_pkg::BAR_W-1:0]     o_bar_level,
    output logic [tll_pkg::LBL_W-1:0]     o_label_index,
    output logic                          o_label_valid,
    // configuration writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire                           i_cfg_index,
    input  wire  [tll_pkg::STEP_W-1:0]    i_cfg_data
);
    import tll_pkg::*;

    localparam logic [STEP_W-1:0] STEP_RESET = 12'd1000;

    logic              r_tank_mode;
    logic [STEP_W-1:0] r_step_volume;

    t_job  fr_job, q_job;
    logic  fr_valid, fr_ready;
    logic  q_valid, q_ready;

    // user writes configuration only while block idle; unchecked, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank_mode   <= 1'b0;
            r_step_volume <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TANK_MODE:   r_tank_mode   <= i_cfg_data[0];
                REG_STEP_VOLUME: r_step_volume <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // locate the interval holding the height
    tll_front #(
        .POINTS      (POINTS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_large      (r_tank_mode),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_height_avg (i_height_avg),
        .o_job_valid  (fr_valid),
        .i_job_ready  (fr_ready),
        .o_job        (fr_job)
    );

    // hold located intervals while the compute side is busy
    tll_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_job   (fr_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    // interpolate and decode
    tll_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_large         (r_tank_mode),
        .i_step          (r_step_volume),
        .i_job_valid     (q_valid),
        .o_job_ready     (q_ready),
        .i_job           (q_job),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_volume_tenths (o_volume_tenths),
        .o_in_table      (o_in_table),
        .o_bar_level     (o_bar_level),
        .o_label_index   (o_label_index),
        .o_label_valid   (o_label_valid)
    );

endmodule : tank_level_linearizer
`default_nettype wire

// ===== design/tll_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tll_front: breakpoint search
// Takes a height word and walks the breakpoint ROM one interval per cycle
// until the height falls inside an interval or the table ends.
// ----------------------------------------------------------------------------
module tll_front #(
    parameter int POINTS      = 31,
    parameter int HEIGHT_BITS = 12
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_large,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [tll_pkg::H_W-1:0]        i_height_avg,
    output logic                           o_job_valid,
    input  wire                            i_job_ready,
    output tll_pkg::t_job                  o_job
);
    import tll_pkg::*;

    localparam int BIG_N   = (POINTS > ROM_DEPTH) ? ROM_DEPTH : POINTS;
    localparam int SMALL_N = (BIG_N < SMALL_POINTS) ? BIG_N : SMALL_POINTS;
    localparam logic [IDX_W-1:0] BIG_LAST   = IDX_W'(BIG_N - 1);
    localparam logic [IDX_W-1:0] SMALL_LAST = IDX_W'(SMALL_N - 1);
    localparam int HB = (HEIGHT_BITS < H_W) ? HEIGHT_BITS : H_W;
    localparam logic [H_W-1:0] H_MASK = H_W'((64'd1 << HB) - 64'd1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SCAN = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [H_W-1:0]   r_h, n_h;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_job             r_job, n_job;

    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] last_pt;
    logic [PT_W-1:0]  lo, hi;
    logic [H_W-1:0]   dh_full;
    logic             found;

    assign idx_next = r_idx + IDX_W'(1);
    assign last_pt  = i_large ? BIG_LAST : SMALL_LAST;
    assign lo       = LEVEL_ROM[r_idx];
    assign hi       = LEVEL_ROM[idx_next];
    // lower bound holds by construction: earlier points were all passed
    assign found    = r_h < {1'b0, hi};
    assign dh_full  = r_h - {1'b0, lo};

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_idx   = r_idx;
        n_job   = r_job;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_h     = i_height_avg & H_MASK;
                    n_idx   = '0;
                    n_state = F_SCAN;
                end
            end
            F_SCAN: begin
                if (found) begin
                    n_job.dh   = dh_full[PT_W-1:0];
                    n_job.span = hi - lo;
                    n_job.idx  = r_idx;
                    n_job.hit  = 1'b1;
                    n_state    = F_PUSH;
                end else if (idx_next == last_pt) begin
                    n_job.dh   = '0;
                    n_job.span = '0;
                    n_job.idx  = r_idx;
                    n_job.hit  = 1'b0;
                    n_state    = F_PUSH;
                end else begin
                    n_idx = idx_next;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_h   <= n_h;
        r_idx <= n_idx;
        r_job <= n_job;
    end

    assign o_in_ready  = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = r_job;

endmodule : tll_front
`default_nettype wire

// ===== design/tll_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tll_queue: two-entry job queue
// Decouples the search from the compute side so each can stall on its own.
// ----------------------------------------------------------------------------
module tll_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push_valid,
    output logic               o_push_ready,
    input  tll_pkg::t_job      i_push_job,
    output logic               o_pop_valid,
    input  wire                i_pop_ready,
    output tll_pkg::t_job      o_pop_job
);
    import tll_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign push = i_push_valid & o_push_ready;
    assign pop  = i_pop_ready & o_pop_valid;
    assign o_pop_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule : tll_queue
`default_nettype wire

// ===== design/tll_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tll_back: interpolation and display decode
// On a hit multiplies, divides with a restoring divider (one quotient bit per
// cycle) and adds the interval base; then decodes bar level and label bucket.
// ----------------------------------------------------------------------------
module tll_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_large,
    input  wire  [tll_pkg::STEP_W-1:0]   i_step,
    input  wire                          i_job_valid,
    output logic                         o_job_ready,
    input  tll_pkg::t_job                i_job,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [tll_pkg::VOL_W-1:0]    o_volume_tenths,
    output logic                         o_in_table,
    output logic [tll_pkg::BAR_W-1:0]    o_bar_level,
    output logic [tll_pkg::LBL_W-1:0]    o_label_index,
    output logic                         o_label_valid
);
    import tll_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_SUM  = 3'd3;
    localparam logic [2:0] B_LBL1 = 3'd4;
    localparam logic [2:0] B_LBL2 = 3'd5;

    localparam logic [3:0] DIV_LAST = 4'(QUO_W - 1);

    logic [2:0]        r_state;
    t_job              r_job;
    logic [BASE_W-1:0] r_base;
    logic [PT_W-1:0]   r_rem;
    logic [QUO_W-1:0]  r_dvd;     // dividend low bits in, quotient out
    logic [3:0]        r_cnt;
    logic [VOL_W-1:0]  r_vol;
    logic [VOL_W-1:0]  r_last;
    logic [KQ_W-1:0]   r_kq;
    logic              r_out_valid;

    logic [PROD_W-1:0]          prod;
    logic [PT_W:0]              trial;
    logic                       ge;
    logic [PT_W:0]              trial_sub;
    logic [SUM_W-1:0]           sum;
    logic [VOL_W+RECIP_W-1:0]   recip_prod;
    logic [VOL_W:0]             k250;
    logic [VOL_W:0]             rdiff;
    logic [7:0]                 rem250;
    logic [BAR_W-1:0]           bar;
    logic [LBL_W-1:0]           lbl_full;
    logic [VOL_W-1:0]           full_lo, full_max;
    logic [LBL_W-1:0]           lbl_idx;
    logic                       lbl_ok;
    logic                       load_out;

    assign prod      = PROD_W'(r_job.dh) * PROD_W'(i_step);
    assign trial     = {r_rem, r_dvd[QUO_W-1]};
    assign ge        = trial >= {1'b0, r_job.span};
    assign trial_sub = trial - {1'b0, r_job.span};
    assign sum       = SUM_W'(r_base) + SUM_W'(r_dvd);
    assign recip_prod = (VOL_W+RECIP_W)'(r_vol) * (VOL_W+RECIP_W)'(LBL_RECIP);
    assign k250      = (VOL_W+1)'(r_kq) * (VOL_W+1)'(LBL_BUCKET);
    assign rdiff     = {1'b0, r_vol} - k250;
    assign rem250    = rdiff[7:0];

    // bar level
    always_comb begin
        if (!i_large) begin
            priority if (r_vol <= BAR_S0) bar = 3'd0;
            else if (r_vol < BAR_S1)      bar = 3'd1;
            else if (r_vol < BAR_S2)      bar = 3'd2;
            else if (r_vol < BAR_S3)      bar = 3'd3;
            else if (r_vol < BAR_S4)      bar = 3'd4;
            else                          bar = 3'd5;
        end else begin
            priority if (r_vol <= BAR_L0) bar = 3'd0;
            else if (r_vol <= BAR_L1)     bar = 3'd1;
            else if (r_vol <= BAR_L2)     bar = 3'd2;
            else if (r_vol <= BAR_L3)     bar = 3'd3;
            else if (r_vol <= BAR_L4)     bar = 3'd4;
            else                          bar = 3'd5;
        end
    end

    // label bucket; the full bucket is wider than the others
    always_comb begin
        lbl_full = i_large ? LBL_FULL_LARGE : LBL_FULL_SMALL;
        full_lo  = i_large ? FULL_LO_LARGE  : FULL_LO_SMALL;
        full_max = i_large ? FULL_MAX_LARGE : FULL_MAX_SMALL;
        if (r_vol >= full_lo) begin
            lbl_ok  = (r_vol <= full_max);
            lbl_idx = lbl_ok ? lbl_full : '0;
        end else begin
            lbl_ok  = (rem250 <= LBL_SPAN_MAX);
            lbl_idx = lbl_ok ? r_kq[LBL_W-1:0] : '0;
        end
    end

    assign load_out = (r_state == B_LBL2) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.hit ? B_MUL : B_LBL1;
                    end
                end
                B_MUL: r_state <= B_DIV;
                B_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= B_SUM;
                    end
                end
                B_SUM: r_state <= B_LBL1;
                B_LBL1: begin
                    r_last  <= r_vol;
                    r_state <= B_LBL2;
                end
                B_LBL2: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // datapath
        if (r_state == B_IDLE && i_job_valid) begin
            r_job  <= i_job;
            r_base <= BASE_W'(i_job.idx) * BASE_W'(i_step);
            r_vol  <= r_last;   // miss: hold the last volume
        end
        if (r_state == B_MUL) begin
            r_rem <= prod[PROD_W-1:QUO_W];
            r_dvd <= prod[QUO_W-1:0];
            r_cnt <= '0;
        end
        if (r_state == B_DIV) begin
            r_rem <= ge ? trial_sub[PT_W-1:0] : trial[PT_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], ge};
            r_cnt <= r_cnt + 4'd1;
        end
        if (r_state == B_SUM) begin
            r_vol <= (sum[SUM_W-1:VOL_W] != '0) ? {VOL_W{1'b1}} : sum[VOL_W-1:0];
        end
        if (r_state == B_LBL1) begin
            r_kq <= recip_prod[LBL_SHIFT+KQ_W-1:LBL_SHIFT];
        end
        if (load_out) begin
            o_volume_tenths <= r_vol;
            o_in_table      <= r_job.hit;
            o_bar_level     <= bar;
            o_label_index   <= lbl_idx;
            o_label_valid   <= lbl_ok;
        end
    end

    assign o_job_ready = (r_state == B_IDLE);
    assign o_out_valid = r_out_valid;

endmodule : tll_back
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tank level linearizer
// Drives height words against a bit-accurate volume predictor. Directed cases
// hit table edges, holds, zero step and label gaps. Random phases vary tank
// mode and step volume, with bursty stalls on both word channels.
// ----------------------------------------------------------------------------
module tb;
    import tll_pkg::*;

    localparam int LARGE_POINTS = 31;
    localparam int HEIGHT_BITS  = 12;
    localparam int VOL_MAX      = 131071;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 200;
    localparam int QUIET_PHASES  = 2;     // final phases run with no idling
    localparam int TAIL_CYCLES   = 40;    // idle time after the drain, so stray readings are flagged

    typedef enum logic {
        TANK_SMALL = 1'b0,
        TANK_LARGE = 1'b1
    } t_tank_mode;

    typedef struct packed {
        logic [VOL_W-1:0] volume;
        logic             in_table;
        logic [BAR_W-1:0] bar;
        logic [LBL_W-1:0] label;
        logic             label_valid;
    } t_level_reading;

    // bench-driven inputs, all known from time zero
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [H_W-1:0]    i_height_avg = '0;
    logic              i_out_ready  = 1'b0;
    logic              i_cfg_valid  = 1'b0;
    logic              i_cfg_index  = 1'b0;
    logic [STEP_W-1:0] i_cfg_data   = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [VOL_W-1:0]  o_volume_tenths;
    logic              o_in_table;
    logic [BAR_W-1:0]  o_bar_level;
    logic [LBL_W-1:0]  o_label_index;
    logic              o_label_valid;
    logic              o_cfg_ready;

    // predictor copy of the register file and the held volume
    t_tank_mode        cur_mode;
    logic [STEP_W-1:0] cur_step;
    logic [VOL_W-1:0]  held_volume;

    t_level_reading    expected_readings[$];
    int                fail_count = 0;
    bit                idle_on    = 1'b1;
    int                ready_stall = 0;

    tank_level_linearizer #(
        .POINTS      (LARGE_POINTS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_height_avg    (i_height_avg),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_volume_tenths (o_volume_tenths),
        .o_in_table      (o_in_table),
        .o_bar_level     (o_bar_level),
        .o_label_index   (o_label_index),
        .o_label_valid   (o_label_valid),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Interpolate one height over the breakpoint table, then decode bar and
    // label from the resulting volume. A miss holds the previous volume.
    function automatic t_level_reading linearize_height(
        input logic [H_W-1:0]    h,
        input t_tank_mode        mode,
        input logic [STEP_W-1:0] step,
        input logic [VOL_W-1:0]  held
    );
        int unsigned    n, hv, sv, lo, hi, v, k, r, full_k, full_max, i;
        bit             found;
        t_level_reading rd;
        n     = (mode == TANK_LARGE) ? LARGE_POINTS : SMALL_POINTS;
        hv    = h & ((1 << HEIGHT_BITS) - 1);
        sv    = step;
        v     = held;
        found = 1'b0;
        if (hv == 0) begin
            v     = 0;
            found = 1'b1;
        end else begin
            for (i = 0; i + 1 < n; i++) begin
                lo = LEVEL_ROM[i];
                hi = LEVEL_ROM[i + 1];
                if (!found && hv >= lo && hv < hi) begin
                    v = ((hv - lo) * sv) / (hi - lo) + i * sv;
                    if (v > VOL_MAX) v = VOL_MAX;
                    found = 1'b1;
                end
            end
        end
        rd.volume   = v[VOL_W-1:0];
        rd.in_table = found;

        if (mode == TANK_SMALL) begin
            if (v <= BAR_S0)     rd.bar = 3'd0;
            else if (v < BAR_S1) rd.bar = 3'd1;
            else if (v < BAR_S2) rd.bar = 3'd2;
            else if (v < BAR_S3) rd.bar = 3'd3;
            else if (v < BAR_S4) rd.bar = 3'd4;
            else                 rd.bar = 3'd5;
        end else begin
            if (v <= BAR_L0)      rd.bar = 3'd0;
            else if (v <= BAR_L1) rd.bar = 3'd1;
            else if (v <= BAR_L2) rd.bar = 3'd2;
            else if (v <= BAR_L3) rd.bar = 3'd3;
            else if (v <= BAR_L4) rd.bar = 3'd4;
            else                  rd.bar = 3'd5;
        end

        // the last bucket stretches up to the full mark; gaps read as index 0
        full_k   = (mode == TANK_LARGE) ? LBL_FULL_LARGE : LBL_FULL_SMALL;
        full_max = (mode == TANK_LARGE) ? FULL_MAX_LARGE : FULL_MAX_SMALL;
        k = v / LBL_BUCKET;
        r = v % LBL_BUCKET;
        if (k >= full_k) begin
            rd.label_valid = (v <= full_max);
            rd.label       = rd.label_valid ? full_k[LBL_W-1:0] : '0;
        end else begin
            rd.label_valid = (r <= LBL_SPAN_MAX);
            rd.label       = rd.label_valid ? k[LBL_W-1:0] : '0;
        end
        return rd;
    endfunction

    // Drive one height word; called at a falling edge, returns at one.
    task automatic send_height(input logic [H_W-1:0] h);
        t_level_reading rd;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_height_avg <= h;
        do @(posedge i_clk); while (!o_in_ready);
        rd = linearize_height(h, cur_mode, cur_step, held_volume);
        held_volume = rd.volume;
        expected_readings.push_back(rd);
        @(negedge i_clk);
    endtask

    // Drop the input word and hold until every predicted reading is back.
    task automatic drain_readings();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_readings.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [STEP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TANK_MODE:   cur_mode = t_tank_mode'(data[0]);
            REG_STEP_VOLUME: cur_step = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reconfigure only with the block idle; upper mode bits are don't-care.
    task automatic configure(input t_tank_mode mode, input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] mode_word;
        drain_readings();
        mode_word = {11'($urandom_range(0, 2047)), mode};
        if ($urandom_range(0, 1)) begin
            write_reg(REG_TANK_MODE, mode_word);
            write_reg(REG_STEP_VOLUME, step);
        end else begin
            write_reg(REG_STEP_VOLUME, step);
            write_reg(REG_TANK_MODE, mode_word);
        end
    endtask

    // Mostly in-table heights, with breakpoint neighbors, zeros and overshoot.
    function automatic logic [H_W-1:0] pick_height(input t_tank_mode mode);
        int unsigned n, top, sel, bp;
        n   = (mode == TANK_LARGE) ? LARGE_POINTS : SMALL_POINTS;
        top = LEVEL_ROM[n - 1];
        sel = $urandom_range(0, 99);
        if (sel < 8) return '0;
        if (sel < 20) begin
            bp = $urandom_range(0, n - 1);
            return H_W'(LEVEL_ROM[bp] + $urandom_range(0, 2) - 1);
        end
        if (sel < 85) return H_W'($urandom_range(1, top - 1));
        if (sel < 92) return H_W'($urandom_range(top, 4095));
        return H_W'($urandom);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) return STEP_W'(1);
        if (sel < 4) return STEP_W'(4095);
        if (sel == 4) return '0;
        return STEP_W'($urandom_range(1, 4095));
    endfunction

    // Defaults after reset: small tank, 100 litres per interval.
    task automatic test_reset_defaults();
        send_height(12'd0);
        send_height(12'd1);
        send_height(12'd50);    // bar 0 edge
        send_height(12'd51);
        send_height(12'd100);
        send_height(12'd482);   // last small interval
        send_height(12'd483);   // past the table: hold
        send_height(12'd4095);
    endtask

    task automatic test_large_extremes();
        configure(TANK_LARGE, 12'd4095);
        send_height(12'd1);
        send_height(12'd1010);
        send_height(12'd1011);
        send_height(12'd1299);  // top of the large table
        send_height(12'd1300);  // hold
        send_height(12'd2048);
    endtask

    task automatic test_zero_step();
        configure(TANK_LARGE, 12'd0);
        send_height(12'd500);
        send_height(12'd1300);
        configure(TANK_SMALL, 12'd1);
        send_height(12'd482);
    endtask

    task automatic test_label_buckets();
        configure(TANK_SMALL, 12'd245);
        send_height(12'd100);   // 24.5 litres: between buckets
        configure(TANK_SMALL, 12'd1000);
        send_height(12'd410);   // inside the full bucket
        configure(TANK_SMALL, 12'd4095);
        send_height(12'd470);   // above the full mark
    endtask

    task automatic test_random_phases();
        t_tank_mode        mode;
        logic [STEP_W-1:0] step;
        int                p, w;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin mode = TANK_SMALL; step = 12'd1;    end
                1:       begin mode = TANK_LARGE; step = 12'd4095; end
                default: begin mode = t_tank_mode'($urandom_range(0, 1)); step = pick_step(); end
            endcase
            configure(mode, step);
            idle_on = (p < RANDOM_PHASES - QUIET_PHASES);
            for (w = 0; w < PHASE_WORDS; w++)
                send_height(pick_height(cur_mode));
        end
    endtask

    // Output side: ready stalls in bursts while idling is on.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_ready <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            ready_stall <= $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted reading against the oldest prediction.
    always @(posedge i_clk) begin
        t_level_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: volume_tenths %0d", o_volume_tenths);
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_volume_tenths !== want.volume) begin
                    $error("volume_tenths: expected %0d, actual %0d",
                           want.volume, o_volume_tenths);
                    fail_count++;
                end
                if (o_in_table !== want.in_table) begin
                    $error("in_table: expected %0d, actual %0d", want.in_table, o_in_table);
                    fail_count++;
                end
                if (o_bar_level !== want.bar) begin
                    $error("bar_level: expected %0d, actual %0d", want.bar, o_bar_level);
                    fail_count++;
                end
                if (o_label_index !== want.label) begin
                    $error("label_index: expected %0d, actual %0d", want.label, o_label_index);
                    fail_count++;
                end
                if (o_label_valid !== want.label_valid) begin
                    $error("label_valid: expected %0d, actual %0d",
                           want.label_valid, o_label_valid);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cur_mode    = TANK_SMALL;
        cur_step    = 12'd1000;
        held_volume = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_large_extremes();
        test_zero_step();
        test_label_buckets();
        test_random_phases();

        drain_readings();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
